FILE: design/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants for the touch report packet deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

    // Packet framing
    localparam logic [3:0] PKT_LEN  = 4'd10;
    localparam logic [3:0] POS_LAST = 4'd9;

    // Characters and checksum seed
    localparam logic [7:0] SUM_SEED = 8'hAA;
    localparam logic [7:0] START_CH = 8'h55;  // 'U'
    localparam logic [7:0] TOUCH_CH = 8'h54;  // 'T'
    localparam logic [7:0] ACK_CH   = 8'h41;  // 'A'

    // Horizontal full scale used to reverse the x axis
    localparam logic [15:0] X_FULL_SCALE = 16'd4096;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_TOUCH = 3'd1,
        EV_ACK   = 3'd2,
        EV_OTHER = 3'd3,
        EV_CSUM  = 3'd4,
        EV_START = 3'd5
    } t_event;

    // Input action codes
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Registered input beat handed from the input stage to the core
    typedef struct packed {
        logic       valid;
        logic       action;
        logic [7:0] rx_byte;
    } t_in_beat;

endpackage

FILE: design/tpd_in_if.sv
// ----------------------------------------------------------------------------
// tpd_in_if
// Input channel: one received byte or gap timeout per beat.
// ----------------------------------------------------------------------------
interface tpd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

FILE: design/tpd_out_if.sv
// ----------------------------------------------------------------------------
// tpd_out_if
// Result channel: event code and latched coordinates per beat.
// ----------------------------------------------------------------------------
interface tpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic        coords_updated;

    modport source (output valid, output event_res, output coord_x, output coord_y,
                    output coords_updated, input ready);
    modport sink   (input valid, input event_res, input coord_x, input coord_y,
                    input coords_updated, output ready);
endinterface

FILE: design/touch_report_packet_deframer.sv
// ----------------------------------------------------------------------------
// touch_report_packet_deframer
// Frames 10-byte touch controller packets and reports touch coordinates.
// ----------------------------------------------------------------------------
// Takes one beat per clock: a received byte or a gap timeout. Each beat gives
// exactly one result beat, passing through the input register and then the
// result register, and a new beat is taken every cycle as long as the
// result side keeps up; a stalled result holds the input register, so at
// most two beats are in flight. Packets start with 'U' and end in a checksum
// byte seeded with 0xAA. A good 'T' packet latches x (reversed against full
// scale 4096, divided by 16) and y (divided by 16) unless the hold flag set
// at reset is still on; the first gap timeout clears it.
// ----------------------------------------------------------------------------
module touch_report_packet_deframer
    import tpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpd_in_if.sink    i_in,
    tpd_out_if.source o_out
);

    t_in_beat w_beat;
    logic     w_advance;

    // Input register
    tpd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_beat    (w_beat)
    );

    // Framing, decode and result register
    tpd_frame_core u_frame_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (w_beat),
        .o_advance (w_advance),
        .o_out     (o_out)
    );

endmodule

FILE: design/tpd_in_stage.sv
// ----------------------------------------------------------------------------
// tpd_in_stage
// Input register: captures one beat, refills in the cycle it drains.
// ----------------------------------------------------------------------------
module tpd_in_stage
    import tpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    tpd_in_if.sink   i_in,
    input  logic     i_advance,
    output t_in_beat o_beat
);

    logic       r_valid;
    logic       r_action;
    logic [7:0] r_rx_byte;
    logic       w_take;

    // Room when empty or when the held beat moves on this cycle
    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action  <= i_in.action;
            r_rx_byte <= i_in.rx_byte;
        end
    end

    assign o_beat = '{valid: r_valid, action: r_action, rx_byte: r_rx_byte};

endmodule

FILE: design/tpd_frame_core.sv
// ----------------------------------------------------------------------------
// tpd_frame_core
// Framing state, checksum, packet decode and the result register.
// ----------------------------------------------------------------------------
module tpd_frame_core
    import tpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_beat,
    output logic      o_advance,
    tpd_out_if.source o_out
);

    // Framing state
    logic [3:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_sum, n_sum;
    logic        r_hold, n_hold;
    logic [11:0] r_lat_x, n_lat_x;
    logic [11:0] r_lat_y, n_lat_y;

    // Packet bytes that are read back: type and two coordinate words
    logic [7:0]  r_pb1, n_pb1;
    logic [7:0]  r_pb3, n_pb3;
    logic [7:0]  r_pb4, n_pb4;
    logic [7:0]  r_pb5, n_pb5;
    logic [7:0]  r_pb6, n_pb6;

    // Result register
    logic        r_out_valid;
    t_event      r_event, n_event;
    logic        r_upd, n_upd;

    logic        w_step;
    logic [3:0]  w_pos;
    logic [15:0] w_diff;
    logic [15:0] w_raw_v;

    // Result slot free when empty or being taken
    assign o_advance = !r_out_valid || o_out.ready;
    assign w_step    = i_beat.valid && o_advance;

    // Out-of-range index restarts the packet
    assign w_pos   = (r_byte_index >= PKT_LEN) ? 4'd0 : r_byte_index;
    assign w_diff  = X_FULL_SCALE - {r_pb4, r_pb3};
    assign w_raw_v = {r_pb6, r_pb5};

    // Next state and result
    always_comb begin
        n_byte_index = r_byte_index;
        n_sum        = r_sum;
        n_hold       = r_hold;
        n_lat_x      = r_lat_x;
        n_lat_y      = r_lat_y;
        n_pb1        = r_pb1;
        n_pb3        = r_pb3;
        n_pb4        = r_pb4;
        n_pb5        = r_pb5;
        n_pb6        = r_pb6;
        n_event      = EV_NONE;
        n_upd        = 1'b0;
        if (w_step) begin
            if (i_beat.action == ACT_TIMEOUT) begin
                n_byte_index = 4'd0;
                n_hold       = 1'b0;
            end else begin
                n_byte_index = w_pos + 4'd1;
                n_sum        = ((w_pos == 4'd0) ? SUM_SEED : r_sum) + i_beat.rx_byte;
                case (w_pos)
                    4'd1:    n_pb1 = i_beat.rx_byte;
                    4'd3:    n_pb3 = i_beat.rx_byte;
                    4'd4:    n_pb4 = i_beat.rx_byte;
                    4'd5:    n_pb5 = i_beat.rx_byte;
                    4'd6:    n_pb6 = i_beat.rx_byte;
                    default: ;
                endcase
                if (w_pos == 4'd0) begin
                    if (i_beat.rx_byte != START_CH) begin
                        n_byte_index = 4'd0;
                        n_event      = EV_START;
                    end
                end else if (w_pos == POS_LAST) begin
                    n_byte_index = 4'd0;
                    if (i_beat.rx_byte != r_sum) begin
                        n_event = EV_CSUM;
                    end else if (r_pb1 == TOUCH_CH) begin
                        n_event = EV_TOUCH;
                        if (!r_hold) begin
                            n_lat_x = w_diff[15:4];
                            n_lat_y = w_raw_v[15:4];
                            n_upd   = 1'b1;
                        end
                    end else if (r_pb1 == ACK_CH) begin
                        n_event = EV_ACK;
                    end else begin
                        n_event = EV_OTHER;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= 4'd0;
            r_sum        <= SUM_SEED;
            r_hold       <= 1'b1;
            r_lat_x      <= 12'd0;
            r_lat_y      <= 12'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
            r_hold       <= n_hold;
            r_lat_x      <= n_lat_x;
            r_lat_y      <= n_lat_y;
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Packet bytes and result payload
    always_ff @(posedge i_clk) begin
        r_pb1 <= n_pb1;
        r_pb3 <= n_pb3;
        r_pb4 <= n_pb4;
        r_pb5 <= n_pb5;
        r_pb6 <= n_pb6;
        if (w_step) begin
            r_event <= n_event;
            r_upd   <= n_upd;
        end
    end

    // Coordinates shown are the latched values after the beat
    logic [11:0] r_out_x;
    logic [11:0] r_out_y;

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_x <= n_lat_x;
            r_out_y <= n_lat_y;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = r_event;
    assign o_out.coord_x        = r_out_x;
    assign o_out.coord_y        = r_out_y;
    assign o_out.coords_updated = r_upd;

endmodule
